/* sv/b64_pkg.sv */
// shared types, constants and alphabet functions for the base64 codec
package b64_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3d;
    localparam logic [6:0] NO_VALUE = 7'd64;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       message_done;
        logic       no_data;
    } out_t;

    // up to four result beats produced by one input beat
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        logic            eom;
        logic            no_data;
    } group_t;

    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] r;
        r = 8'h00;
        priority if (v < 6'd26)
            r = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'h61 + ({2'b00, v} - 8'd26);
        else if (v < 6'd62)
            r = 8'h30 + ({2'b00, v} - 8'd52);
        else if (v == 6'd62)
            r = 8'h2b;
        else
            r = 8'h2f;
        return r;
    endfunction

    function automatic logic [6:0] char_value(input logic [7:0] ch);
        logic [6:0] r;
        r = NO_VALUE;
        priority if (ch >= 8'h41 && ch <= 8'h5a)
            r = 7'(ch - 8'h41);
        else if (ch >= 8'h61 && ch <= 8'h7a)
            r = 7'(ch - 8'h61 + 8'd26);
        else if (ch >= 8'h30 && ch <= 8'h39)
            r = 7'(ch - 8'h30 + 8'd52);
        else if (ch == 8'h2b)
            r = 7'd62;
        else if (ch == 8'h2f)
            r = 7'd63;
        else
            r = NO_VALUE;
        return r;
    endfunction

endpackage

/* sv/b64_group.sv */
// group state, mode register and per-beat encode/decode logic
module b64_group (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  b64_pkg::in_t    in_beat,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    output b64_pkg::group_t grp,
    output logic            grp_valid
);

    b64_pkg::mode_t  mode_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic [2:0][7:0] held_reg;
    logic [7:0]      held_wdata;

    logic [7:0] b;
    logic       eom;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [6:0] v0;
    logic [6:0] v1;
    logic [6:0] v2;
    logic [6:0] v3;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic       v2_ok;
    logic       v3_ok;

    assign b   = in_beat.in_byte;
    assign eom = in_beat.end_of_message;

    assign b0 = (count_reg == 2'd0) ? b : held_reg[0];
    assign b1 = (count_reg == 2'd1) ? b : held_reg[1];

    assign v0 = held_reg[0][6:0];
    assign v1 = held_reg[1][6:0];
    assign v2 = held_reg[2][6:0];
    assign v3 = b64_pkg::char_value(b);

    // decoded bytes wrap to 8 bits, pad values take part in all three sums
    assign d0    = {v0[5:0], 2'b00} + {5'b00000, v1[6:4]};
    assign d1    = {v1[3:0], 4'b0000} + {3'b000, v2[6:2]};
    assign d2    = {v2[1:0], 6'b000000} + {1'b0, v3};
    assign v2_ok = (v2 != b64_pkg::NO_VALUE);
    assign v3_ok = (v3 != b64_pkg::NO_VALUE);

    always_comb
    begin
        grp        = '0;
        grp.eom    = eom;
        grp_valid  = 1'b0;
        count_next = count_reg;
        held_wdata = b;
        if (mode_reg == b64_pkg::MODE_ENCODE)
        begin
            held_wdata = b;
            count_next = (count_reg == 2'd2 || eom) ? 2'd0 : count_reg + 2'd1;
            grp.last_idx = 2'd3;
            grp.data[0]  = b64_pkg::sym(b0[7:2]);
            unique case (count_reg)
                2'd2:
                begin
                    grp_valid   = 1'b1;
                    grp.data[1] = b64_pkg::sym({b0[1:0], b1[7:4]});
                    grp.data[2] = b64_pkg::sym({held_reg[1][3:0], b[7:6]});
                    grp.data[3] = b64_pkg::sym(b[5:0]);
                end
                2'd1:
                begin
                    grp_valid   = eom;
                    grp.data[1] = b64_pkg::sym({b0[1:0], b1[7:4]});
                    grp.data[2] = b64_pkg::sym({b1[3:0], 2'b00});
                    grp.data[3] = b64_pkg::PAD_CHAR;
                end
                2'd0:
                begin
                    grp_valid   = eom;
                    grp.data[1] = b64_pkg::sym({b0[1:0], 4'b0000});
                    grp.data[2] = b64_pkg::PAD_CHAR;
                    grp.data[3] = b64_pkg::PAD_CHAR;
                end
                default:
                begin
                    grp_valid = 1'b0;
                end
            endcase
        end
        else
        begin
            held_wdata = {1'b0, v3};
            count_next = eom ? 2'd0 : count_reg + 2'd1;
            if (count_reg == 2'd3)
            begin
                grp_valid    = 1'b1;
                grp.data[0]  = d0;
                grp.data[1]  = v2_ok ? d1 : d2;
                grp.data[2]  = d2;
                grp.last_idx = {1'b0, v2_ok} + {1'b0, v3_ok};
            end
            else if (eom)
            begin
                // end marker with no byte
                grp_valid    = 1'b1;
                grp.no_data  = 1'b1;
                grp.last_idx = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= b64_pkg::MODE_ENCODE;
            count_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            mode_reg  <= b64_pkg::mode_t'(cfg_wdata);
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && count_reg != 2'd3)
        begin
            held_reg[count_reg] <= held_wdata;
        end
    end

endmodule

/* sv/b64_drain.sv */
// pending group register and output stage that sends one beat per cycle while out_ready is high
module b64_drain (
    input  logic            clk,
    input  logic            rst_n,
    input  b64_pkg::group_t grp,
    input  logic            grp_load,
    output logic            pend_free,
    output logic            out_valid,
    input  logic            out_ready,
    output b64_pkg::out_t   out_data
);

    b64_pkg::group_t pend_reg;
    logic            pend_valid_reg;
    b64_pkg::group_t cur_reg;
    logic            cur_valid_reg;
    logic [1:0]      idx_reg;

    logic is_last;
    logic cur_free;
    logic move;

    assign is_last   = (idx_reg == cur_reg.last_idx);
    assign cur_free  = !cur_valid_reg || (out_ready && is_last);
    assign move      = cur_free && pend_valid_reg;
    assign pend_free = !pend_valid_reg;

    assign out_valid             = cur_valid_reg;
    assign out_data.out_byte     = cur_reg.data[idx_reg];
    assign out_data.last_of_run  = is_last;
    assign out_data.message_done = is_last && cur_reg.eom;
    assign out_data.no_data      = cur_reg.no_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            pend_valid_reg <= (pend_valid_reg && !move) || grp_load;
            if (cur_free)
            begin
                cur_valid_reg <= pend_valid_reg;
                idx_reg       <= 2'd0;
            end
            else if (out_ready)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            pend_reg <= grp;
        end
        if (move)
        begin
            cur_reg <= pend_reg;
        end
    end

endmodule

/* sv/base64_codec.sv */
// streaming base64 encoder / decoder top level
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  in      | input     | in_valid/in_ready  | in_data  (b64_pkg::in_t)
//  out     | output    | out_valid/out_ready| out_data (b64_pkg::out_t)
//  cfg     | input     | cfg_we             | cfg_wdata (mode)
//
// an input beat is taken while in_ready is high; a beat that completes a group loads
// up to four result beats into a pending register, sent one per cycle while out_ready is high
// the single output port sets throughput: 4 beats per 3 bytes encoding
// a beat that closes nothing is taken at once while the pending slot is free
// in_ready does not depend on out_ready; stalls on out hold in at the slot
// rst_n clears mode to encode and drops any partial group
module base64_codec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  b64_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output b64_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);

    b64_pkg::group_t grp;
    logic            grp_valid;
    logic            accept;

    assign accept = in_valid && in_ready;

    b64_group u_group (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_beat   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .grp       (grp),
        .grp_valid (grp_valid)
    );

    b64_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .grp_load  (accept && grp_valid),
        .pend_free (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* sv/b64_checker.sv */
// port-level checks for the base64 codec and their bind
module b64_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input b64_pkg::out_t out_data
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    // the rest of a run follows without a gap
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
        else $error("gap inside a result run");

    // end marker is a lone zero beat closing the message
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_data |->
            out_data.out_byte == 8'h00 && out_data.last_of_run && out_data.message_done)
        else $error("malformed end marker");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.message_done |-> out_data.last_of_run)
        else $error("message end not on last beat of run");

endmodule

bind base64_codec b64_checker u_b64_checker (.*);
